[hw/rtl/dmrem_pkg.sv]
package dmrem_pkg;

	// Field widths
	localparam int unsigned LVL_W  = 18;
	localparam int unsigned MS_W   = 16;
	localparam int unsigned DT_W   = 10;
	localparam int unsigned DRV_W  = 16;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// Divider sizes
	localparam int unsigned DIV_DVD_W = 32;
	localparam int unsigned DIV_DVS_W = 16;

	// Operation codes
	localparam logic [2:0] OP_FRAME   = 3'd0;
	localparam logic [2:0] OP_CHARGE  = 3'd1;
	localparam logic [2:0] OP_FIRE    = 3'd2;
	localparam logic [2:0] OP_VAN_SET = 3'd3;
	localparam logic [2:0] OP_VAN_MAX = 3'd4;

	// Register indexes
	localparam logic [2:0] REG_SCALE     = 3'd0;
	localparam logic [2:0] REG_RATE_L    = 3'd1;
	localparam logic [2:0] REG_RATE_H    = 3'd2;
	localparam logic [2:0] REG_CAP_L     = 3'd3;
	localparam logic [2:0] REG_CAP_H     = 3'd4;
	localparam logic [2:0] REG_WAIT_L    = 3'd5;
	localparam logic [2:0] REG_WAIT_H    = 3'd6;
	localparam logic [2:0] REG_HOLD      = 3'd7;

	// Fixed-point constants
	localparam logic [17:0] LVL_MAX  = 18'h3FFFF;
	localparam logic [17:0] LVL_FULL = 18'd65536;
	localparam logic [17:0] HIT_RMAX = 18'd131072;
	localparam logic [17:0] SCALE_RST = 18'd65536;
	// Reciprocals: /10 as *Q10>>26, /1000 as *Q1000>>38, /3 as *Q3>>17
	localparam logic [31:0] Q10   = 32'd6710887;
	localparam logic [31:0] Q1000 = 32'd274877907;
	localparam logic [31:0] Q3    = 32'd43691;
	localparam logic [9:0]  DT_MAX      = 10'd500;
	localparam logic [9:0]  VAN_IDLE0   = 10'd100;
	localparam logic [9:0]  VAN_IDLE_Z  = 10'd434;
	localparam logic [9:0]  VAN_IDLE_MX = 10'd1023;
	localparam logic [16:0] PT_MAX      = 17'h1FFFF;
	localparam logic [10:0] HIT_T_MAX   = 11'h7FF;
	localparam logic [15:0] DEF_LEN     = 16'd100;
	localparam logic [10:0] HIT_MIN_L   = 11'd80;
	localparam logic [10:0] HIT_MIN_H   = 11'd60;

	typedef struct packed {
		logic [17:0] scale;
		logic [15:0] rate_l;
		logic [15:0] rate_h;
		logic [17:0] cap_l;
		logic [17:0] cap_h;
		logic [15:0] wait_l;
		logic [15:0] wait_h;
		logic [15:0] hold;
	} cfg_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_DVD_W-1:0] dividend;
		logic [DIV_DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

[hw/rtl/dmrem_ifs.sv]
// Input item channel.
interface dmrem_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [17:0] strength_light;
	logic [17:0] strength_heavy;
	logic [15:0] length_light;
	logic [15:0] length_heavy;
	logic [15:0] delay_light;
	logic [15:0] delay_heavy;
	logic [15:0] decay_light;
	logic [15:0] decay_heavy;
	logic [9:0]  elapsed_ms;
	logic [15:0] cur_health;
	logic [15:0] max_health;
	modport source(output valid, operation, strength_light, strength_heavy, length_light,
		length_heavy, delay_light, delay_heavy, decay_light, decay_heavy, elapsed_ms,
		cur_health, max_health, input ready);
	modport sink(input valid, operation, strength_light, strength_heavy, length_light,
		length_heavy, delay_light, delay_heavy, decay_light, decay_heavy, elapsed_ms,
		cur_health, max_health, output ready);
endinterface

// Result channel.
interface dmrem_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] left_speed;
	logic [15:0] right_speed;
	modport source(output valid, left_speed, right_speed, input ready);
	modport sink(input valid, left_speed, right_speed, output ready);
endinterface

[hw/rtl/dual_motor_rumble_envelope_mixer.sv]
// Two-motor rumble envelope mixer. One item is taken at a time: ready is high only while
// the sequencer is idle. A frame that starts a damage pulse also passes through the 32-step
// divider for the damage ratio. Most products and every constant division pass through one
// shared 32x32 multiplier, one product per cycle. A finished result waits in the output
// register; the next item is taken while it waits. Frame and charge items with a step of
// zero or above 500 ms, fire items with both strengths zero and unknown operation codes
// give no result.
module dual_motor_rumble_envelope_mixer import dmrem_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	dmrem_in_if.sink          item,
	dmrem_out_if.source       result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	typedef enum logic [27:0] {
		S_IDLE  = 28'h0000001,
		S_DEC   = 28'h0000002,
		S_TIME  = 28'h0000004,
		S_CHG0  = 28'h0000008,
		S_CHG1  = 28'h0000010,
		S_CHG2  = 28'h0000020,
		S_HOLD  = 28'h0000040,
		S_HLTH  = 28'h0000080,
		S_DIV   = 28'h0000100,
		S_HIT0  = 28'h0000200,
		S_HIT1  = 28'h0000400,
		S_HIT2  = 28'h0000800,
		S_HIT3  = 28'h0001000,
		S_HIT4  = 28'h0002000,
		S_FIRE0 = 28'h0004000,
		S_FIRE1 = 28'h0008000,
		S_VAN   = 28'h0010000,
		S_EV0   = 28'h0020000,
		S_EV1   = 28'h0040000,
		S_EV2   = 28'h0080000,
		S_EV3   = 28'h0100000,
		S_EV4   = 28'h0200000,
		S_EV5   = 28'h0400000,
		S_EV6   = 28'h0800000,
		S_EV7   = 28'h1000000,
		S_EV8   = 28'h2000000,
		S_EV9   = 28'h4000000,
		S_EMIT  = 28'h8000000
	} state_t;

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;
	state_t   state_q;

	// Latched item
	logic [2:0]  op_q;
	logic [17:0] sl_q, sh_q;
	logic [15:0] len_l_q, len_h_q, dly_l_q, dly_h_q, dec_l_q, dec_h_q;
	logic [9:0]  dt_q;
	logic [15:0] cur_q, mx_q;

	// Envelope state
	logic [16:0]        pulse_time_q;
	logic               pulse_on_q;
	logic [1:0][17:0]   peak_q;
	logic [1:0][15:0]   plen_q, pdly_q, pdec_q;
	logic [1:0][17:0]   chg_lvl_q;
	logic [1:0][15:0]   chg_wait_q;
	logic [1:0]         chg_rev_q;
	logic signed [17:0] hold_q;
	logic               charging_q;
	logic [1:0][17:0]   van_q;
	logic [9:0]         van_idle_q;
	logic [1:0][17:0]   hit_lvl_q;
	logic [1:0][10:0]   hit_len_q;
	logic [10:0]        hit_time_q;
	logic               hit_on_q;
	logic [15:0]        last_hp_q;
	logic               last_hp_vld_q;
	logic [1:0][15:0]   last_drv_q;

	// Working registers
	logic [17:0] r_q, pl_q, ph_q, ch_q, vl_q, lvl_r_q;
	logic [10:0] ll_q, lh_q;
	logic [15:0] drv_l_q, drv_r_q;
	logic        emit_q;
	logic        out_vld_q;
	logic [15:0] out_l_q, out_r_q;

	// Shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	dmrem_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	dmrem_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(mul_p));

	dmrem_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	function automatic logic [17:0] sat18(input logic [47:0] v);
		return (v > 48'(LVL_MAX)) ? LVL_MAX : v[17:0];
	endfunction

	function automatic logic [17:0] charge_next(input logic [17:0] lvl,
		input logic [25:0] step, input logic rev, input logic [17:0] cap);
		logic [26:0] lv;
		if (!rev) lv = 27'(lvl) + 27'(step);
		else lv = (27'(lvl) > 27'(step)) ? 27'(lvl) - 27'(step) : '0;
		if (cap != '0 && lv > 27'(cap)) lv = 27'(cap);
		return sat18(48'(lv));
	endfunction

	function automatic logic [15:0] wait_next(input logic [15:0] w, input logic [9:0] dt);
		return (w > 16'(dt)) ? w - 16'(dt) : '0;
	endfunction

	function automatic logic [15:0] drive_of(input logic [19:0] m);
		if (m >= 20'(LVL_FULL)) return 16'hFFFF;
		else if (m == '0) return '0;
		else return m[15:0] - 16'd1;
	endfunction

	function automatic logic [17:0] pulse_of(input logic [63:0] fall, input logic [17:0] peak,
		input logic en);
		if (!en || fall >= 64'(peak)) return '0;
		else return peak - fall[17:0];
	endfunction

	function automatic logic [17:0] max3(input logic [17:0] a, input logic [17:0] b,
		input logic [17:0] c);
		logic [17:0] t;
		t = (a > b) ? a : b;
		return (t > c) ? t : c;
	endfunction

	// Item decode and derived values.
	logic        bad_item;
	logic [16:0] pend0, pend1, poff0, poff1;
	logic        win0, win1;
	logic [11:0] tri_idle, f_raw;
	logic [9:0]  f_mul;
	logic        fade, van_zero;
	logic [15:0] drop;
	logic [21:0] drop50;
	logic        hit_cond;
	logic        at_max;
	logic [18:0] fsum0, fsum1;
	logic [21:0] fy;
	logic [20:0] c7;
	logic [19:0] r7;
	logic [17:0] vh_new, cl, wl_s, wh_s, lvl_l, dl, dh;
	logic [18:0] wl_sum, wh_sum;
	logic [15:0] mr_drv;
	logic signed [17:0] hold_base, hold_new;

	always_comb begin
		bad_item = 1'b0;
		case (op_q)
			OP_FRAME, OP_CHARGE: bad_item = (dt_q == '0) || (dt_q > DT_MAX);
			OP_FIRE:             bad_item = (sl_q == '0) && (sh_q == '0);
			OP_VAN_SET, OP_VAN_MAX: bad_item = 1'b0;
			default:             bad_item = 1'b1;
		endcase

		pend0 = {1'b0, pdly_q[0]} + {1'b0, plen_q[0]};
		pend1 = {1'b0, pdly_q[1]} + {1'b0, plen_q[1]};
		poff0 = pulse_time_q - {1'b0, pdly_q[0]};
		poff1 = pulse_time_q - {1'b0, pdly_q[1]};
		win0  = pulse_on_q && pulse_time_q >= {1'b0, pdly_q[0]} && pulse_time_q < pend0;
		win1  = pulse_on_q && pulse_time_q >= {1'b0, pdly_q[1]} && pulse_time_q < pend1;

		tri_idle = {1'b0, van_idle_q, 1'b0} + {2'b00, van_idle_q};
		f_raw    = 12'd1300 - tri_idle;
		fade     = van_idle_q > VAN_IDLE0;
		van_zero = van_idle_q >= VAN_IDLE_Z;
		f_mul    = fade ? f_raw[9:0] : 10'd1000;

		drop     = last_hp_q - cur_q;
		drop50   = {drop, 5'b0} + {1'b0, drop, 4'b0} + {5'b0, drop, 1'b0};
		hit_cond = last_hp_vld_q && mx_q != '0 && last_hp_q != '0 && cur_q < last_hp_q
			&& drop50 > 22'(cur_q);

		at_max = (cfg.cap_l == '0 || chg_lvl_q[0] >= cfg.cap_l)
			&& (cfg.cap_h == '0 || chg_lvl_q[1] >= cfg.cap_h);
		hold_base = (hold_q < 0) ? $signed({2'b00, cfg.hold}) : hold_q;
		hold_new  = hold_base - $signed({8'b0, dt_q});

		fsum0 = {1'b0, sl_q} + {1'b0, chg_lvl_q[0]};
		fsum1 = {1'b0, sh_q} + {1'b0, chg_lvl_q[1]};
		fy    = {fsum1, 3'b0} - {3'b0, fsum1};
		c7    = {chg_lvl_q[1], 3'b0} - {3'b0, chg_lvl_q[1]};
		r7    = {r_q[16:0], 3'b0} - {2'b0, r_q};

		// Level mix, valid in S_EV7 and S_EV9.
		vh_new = van_zero ? '0 : 18'(mul_p[63:38]);
		cl     = charging_q ? chg_lvl_q[0] : '0;
		wl_sum = {1'b0, pl_q} + {1'b0, cl};
		wh_sum = {1'b0, ph_q} + {1'b0, ch_q};
		wl_s   = (wl_sum > 19'(LVL_FULL)) ? LVL_FULL : wl_sum[17:0];
		wh_s   = (wh_sum > 19'(LVL_FULL)) ? LVL_FULL : wh_sum[17:0];
		dl     = (hit_on_q && hit_time_q < hit_len_q[0]) ? hit_lvl_q[0] : '0;
		dh     = (hit_on_q && hit_time_q < hit_len_q[1]) ? hit_lvl_q[1] : '0;
		lvl_l  = max3(vh_new, wh_s, dh);
		mr_drv = drive_of(mul_p[35:16]);
	end

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_CHG0:  begin mul_a = 32'(cfg.rate_l); mul_b = 32'(dt_q); end
			S_CHG1:  begin mul_a = 32'(cfg.rate_h); mul_b = 32'(dt_q); end
			S_HIT0:  begin mul_a = 32'(r_q); mul_b = 32'd1000; end
			S_HIT1:  begin mul_a = 32'(r_q); mul_b = 32'd5000; end
			S_HIT2:  begin mul_a = mul_p[48:17]; mul_b = Q3; end
			S_HIT3:  begin mul_a = 32'(r7); mul_b = Q10; end
			S_FIRE0: begin mul_a = 32'(fy); mul_b = Q10; end
			S_EV0:   begin mul_a = 32'(pdec_q[0]); mul_b = 32'(poff0); end
			S_EV1:   begin mul_a = 32'(pdec_q[1]); mul_b = 32'(poff1); end
			S_EV2:   begin mul_a = 32'(c7); mul_b = Q10; end
			S_EV3:   begin mul_a = 32'(van_q[0]); mul_b = 32'(f_mul); end
			S_EV4:   begin mul_a = mul_p[31:0]; mul_b = Q1000; end
			S_EV5:   begin mul_a = 32'(van_q[1]); mul_b = 32'(f_mul); end
			S_EV6:   begin mul_a = mul_p[31:0]; mul_b = Q1000; end
			S_EV7:   begin mul_a = 32'(lvl_l); mul_b = 32'(cfg.scale); end
			S_EV8:   begin mul_a = 32'(lvl_r_q); mul_b = 32'(cfg.scale); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign div_req.start    = (state_q == S_HLTH) && hit_cond;
	assign div_req.dividend = {drop, 16'b0};
	assign div_req.divisor  = mx_q;

	assign item.ready         = (state_q == S_IDLE);
	assign result.valid       = out_vld_q;
	assign result.left_speed  = out_l_q;
	assign result.right_speed = out_r_q;

	// Item capture on transfer.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_q    <= item.operation;
			sl_q    <= item.strength_light;
			sh_q    <= item.strength_heavy;
			len_l_q <= item.length_light;
			len_h_q <= item.length_heavy;
			dly_l_q <= item.delay_light;
			dly_h_q <= item.delay_heavy;
			dec_l_q <= item.decay_light;
			dec_h_q <= item.decay_heavy;
			dt_q    <= item.elapsed_ms;
			cur_q   <= item.cur_health;
			mx_q    <= item.max_health;
		end
	end

	// Sequencer and envelope state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pulse_time_q  <= '0;
			pulse_on_q    <= 1'b0;
			peak_q        <= '0;
			plen_q        <= '0;
			pdly_q        <= '0;
			pdec_q        <= '0;
			chg_lvl_q     <= '0;
			chg_wait_q    <= '0;
			chg_rev_q     <= '0;
			hold_q        <= -18'sd1;
			charging_q    <= 1'b0;
			van_q         <= '0;
			van_idle_q    <= '0;
			hit_lvl_q     <= '0;
			hit_len_q     <= '0;
			hit_time_q    <= '0;
			hit_on_q      <= 1'b0;
			last_hp_q     <= '0;
			last_hp_vld_q <= 1'b0;
			last_drv_q    <= '0;
			r_q           <= '0;
			pl_q          <= '0;
			ph_q          <= '0;
			ch_q          <= '0;
			vl_q          <= '0;
			lvl_r_q       <= '0;
			ll_q          <= '0;
			lh_q          <= '0;
			drv_l_q       <= '0;
			drv_r_q       <= '0;
			emit_q        <= 1'b0;
			out_vld_q     <= 1'b0;
			out_l_q       <= '0;
			out_r_q       <= '0;
		end else begin
			if (out_vld_q && result.ready) out_vld_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (item.valid) state_q <= S_DEC;
				end

				S_DEC: begin
					if (bad_item) state_q <= S_IDLE;
					else if (op_q == OP_FRAME || op_q == OP_CHARGE) state_q <= S_TIME;
					else if (op_q == OP_FIRE) state_q <= S_FIRE0;
					else state_q <= S_VAN;
				end

				// Advance the time base and enter or leave a charge cycle.
				S_TIME: begin
					pulse_time_q <= (18'(pulse_time_q) + 18'(dt_q) > 18'(PT_MAX)) ? PT_MAX
						: pulse_time_q + 17'(dt_q);
					van_idle_q <= (11'(van_idle_q) + 11'(dt_q) > 11'(VAN_IDLE_MX))
						? VAN_IDLE_MX : van_idle_q + dt_q;
					hit_time_q <= (12'(hit_time_q) + 12'(dt_q) > 12'(HIT_T_MAX)) ? HIT_T_MAX
						: hit_time_q + 11'(dt_q);
					if (op_q == OP_CHARGE) begin
						if (!charging_q) begin
							chg_wait_q[0] <= cfg.wait_l;
							chg_wait_q[1] <= cfg.wait_h;
							chg_rev_q     <= '0;
							hold_q        <= -18'sd1;
						end
						charging_q <= 1'b1;
						state_q    <= S_CHG0;
					end else begin
						if (charging_q) begin
							charging_q <= 1'b0;
							chg_wait_q <= '0;
							chg_rev_q  <= '0;
							hold_q     <= -18'sd1;
						end
						state_q <= S_HLTH;
					end
				end

				S_CHG0: state_q <= S_CHG1;

				// Light motor charge step.
				S_CHG1: begin
					if (chg_wait_q[0] != '0) chg_wait_q[0] <= wait_next(chg_wait_q[0], dt_q);
					else if (cfg.rate_l != '0) chg_lvl_q[0] <= charge_next(chg_lvl_q[0],
						mul_p[25:0], chg_rev_q[0], cfg.cap_l);
					state_q <= S_CHG2;
				end

				// Heavy motor charge step.
				S_CHG2: begin
					if (chg_wait_q[1] != '0) chg_wait_q[1] <= wait_next(chg_wait_q[1], dt_q);
					else if (cfg.rate_h != '0) chg_lvl_q[1] <= charge_next(chg_lvl_q[1],
						mul_p[25:0], chg_rev_q[1], cfg.cap_h);
					state_q <= S_HOLD;
				end

				// Hold at the caps, then reverse.
				S_HOLD: begin
					if (at_max && cfg.hold != '0) begin
						hold_q <= hold_new;
						if (hold_new <= 0) chg_rev_q <= 2'b11;
					end
					state_q <= S_HLTH;
				end

				// Health sample; a large drop starts the ratio division.
				S_HLTH: begin
					last_hp_q     <= cur_q;
					last_hp_vld_q <= 1'b1;
					state_q       <= hit_cond ? S_DIV : S_EV0;
				end

				S_DIV: begin
					if (div_rsp.done) begin
						r_q <= (div_rsp.quotient > 32'(HIT_RMAX)) ? HIT_RMAX
							: div_rsp.quotient[17:0];
						state_q <= S_HIT0;
					end
				end

				S_HIT0: state_q <= S_HIT1;

				S_HIT1: begin
					ll_q    <= mul_p[26:16];
					state_q <= S_HIT2;
				end

				S_HIT2: state_q <= S_HIT3;

				S_HIT3: begin
					lh_q    <= mul_p[27:17];
					state_q <= S_HIT4;
				end

				// Damage pulse levels and lengths.
				S_HIT4: begin
					hit_lvl_q[0] <= sat18({29'b0, r_q, 1'b0});
					hit_lvl_q[1] <= sat18(mul_p[63:16] >> 10);
					hit_len_q[0] <= (ll_q < HIT_MIN_L) ? HIT_MIN_L : ll_q;
					hit_len_q[1] <= (lh_q < HIT_MIN_H) ? HIT_MIN_H : lh_q;
					hit_time_q   <= '0;
					hit_on_q     <= 1'b1;
					state_q      <= S_EV0;
				end

				S_FIRE0: begin
					peak_q[0] <= sat18(48'(fsum0));
					state_q   <= S_FIRE1;
				end

				// Arm the fire pulse.
				S_FIRE1: begin
					peak_q[1]    <= sat18(mul_p[63:16] >> 10);
					plen_q[0]    <= (len_l_q == '0) ? DEF_LEN : len_l_q;
					plen_q[1]    <= (len_h_q == '0) ? DEF_LEN : len_h_q;
					pdly_q[0]    <= dly_l_q;
					pdly_q[1]    <= dly_h_q;
					pdec_q[0]    <= dec_l_q;
					pdec_q[1]    <= dec_h_q;
					pulse_time_q <= '0;
					pulse_on_q   <= 1'b1;
					state_q      <= S_EV0;
				end

				// Vanilla set or max-merge.
				S_VAN: begin
					if (op_q == OP_VAN_SET) begin
						van_q[0] <= sl_q;
						van_q[1] <= sh_q;
					end else begin
						van_q[0] <= (sl_q > van_q[0]) ? sl_q : van_q[0];
						van_q[1] <= (sh_q > van_q[1]) ? sh_q : van_q[1];
					end
					van_idle_q <= '0;
					state_q    <= S_EV0;
				end

				S_EV0: state_q <= S_EV1;

				S_EV1: begin
					pl_q    <= pulse_of(mul_p, peak_q[0], win0);
					state_q <= S_EV2;
				end

				S_EV2: begin
					ph_q    <= pulse_of(mul_p, peak_q[1], win1);
					state_q <= S_EV3;
				end

				S_EV3: begin
					ch_q    <= charging_q ? sat18(mul_p[63:16] >> 10) : '0;
					state_q <= S_EV4;
				end

				S_EV4: state_q <= S_EV5;

				S_EV5: begin
					vl_q    <= van_zero ? '0 : 18'(mul_p[63:38]);
					state_q <= S_EV6;
				end

				S_EV6: state_q <= S_EV7;

				// Max-wins mix per motor.
				S_EV7: begin
					lvl_r_q <= max3(vl_q, wl_s, dl);
					state_q <= S_EV8;
				end

				S_EV8: begin
					drv_l_q <= drive_of(mul_p[35:16]);
					state_q <= S_EV9;
				end

				// Right drive, source retirement and the emit decision.
				S_EV9: begin
					drv_r_q <= mr_drv;
					emit_q  <= !(drv_l_q == '0 && mr_drv == '0 && last_drv_q[0] == '0
						&& last_drv_q[1] == '0);
					if (pulse_on_q && pulse_time_q >= pend0 && pulse_time_q >= pend1)
						pulse_on_q <= 1'b0;
					if (hit_on_q && hit_time_q >= hit_len_q[0] && hit_time_q >= hit_len_q[1])
						hit_on_q <= 1'b0;
					if (van_zero) van_q <= '0;
					state_q <= S_EMIT;
				end

				// Hand the result to the output register once it is free; a repeated all-zero result is dropped.
				S_EMIT: begin
					if (!emit_q) begin
						state_q <= S_IDLE;
					end else if (!out_vld_q || result.ready) begin
						out_vld_q     <= 1'b1;
						out_l_q       <= drv_l_q;
						out_r_q       <= drv_r_q;
						last_drv_q[0] <= drv_l_q;
						last_drv_q[1] <= drv_r_q;
						state_q       <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/dmrem_mul.sv]
// Shared multiplier with a registered product.
module dmrem_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

endmodule

[hw/rtl/dmrem_div.sv]
// Restoring divider, one quotient bit per cycle.
module dmrem_div import dmrem_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(DIV_DVD_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DVS_W-1:0] rem_q;
	logic [DIV_DVD_W-1:0] quo_q;
	logic [DIV_DVS_W-1:0] dvs_q;
	logic [DIV_DVS_W:0]   shifted;
	logic [DIV_DVS_W:0]   diff;
	logic                 fits;

	// One trial subtraction.
	always_comb begin
		shifted = {rem_q, quo_q[DIV_DVD_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		fits    = shifted >= {1'b0, dvs_q};
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_DVS_W-1:0] : shifted[DIV_DVS_W-1:0];
			quo_q <= {quo_q[DIV_DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[hw/rtl/dmrem_regs.sv]
// Configuration registers behind the APB-style port.
module dmrem_regs import dmrem_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= '0;
			cfg_q.scale <= SCALE_RST;
		end else if (wr) begin
			case (idx)
				REG_SCALE:  cfg_q.scale  <= pwdata[17:0];
				REG_RATE_L: cfg_q.rate_l <= pwdata[15:0];
				REG_RATE_H: cfg_q.rate_h <= pwdata[15:0];
				REG_CAP_L:  cfg_q.cap_l  <= pwdata[17:0];
				REG_CAP_H:  cfg_q.cap_h  <= pwdata[17:0];
				REG_WAIT_L: cfg_q.wait_l <= pwdata[15:0];
				REG_WAIT_H: cfg_q.wait_h <= pwdata[15:0];
				REG_HOLD:   cfg_q.hold   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (idx)
			REG_SCALE:  prdata = DATA_W'(cfg_q.scale);
			REG_RATE_L: prdata = DATA_W'(cfg_q.rate_l);
			REG_RATE_H: prdata = DATA_W'(cfg_q.rate_h);
			REG_CAP_L:  prdata = DATA_W'(cfg_q.cap_l);
			REG_CAP_H:  prdata = DATA_W'(cfg_q.cap_h);
			REG_WAIT_L: prdata = DATA_W'(cfg_q.wait_l);
			REG_WAIT_H: prdata = DATA_W'(cfg_q.wait_h);
			REG_HOLD:   prdata = DATA_W'(cfg_q.hold);
			default:    prdata = '0;
		endcase
	end

endmodule

[hw/rtl/dmrem_chk.sv]
// Port-level checks for the envelope mixer.
module dmrem_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] left_speed,
	input logic [15:0] right_speed
);

	logic prev_zero_q;

	// Track whether the last delivered result was all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_zero_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			prev_zero_q <= (left_speed == '0) && (right_speed == '0);
		end
	end

	// A waiting result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_speed) && $stable(right_speed))
		else $error("result changed while stalled");

	// One item at a time: ready drops after a transfer.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	// A new result only appears at the end of an item's work.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without an item in progress");

	// Two all-zero results never follow each other.
	a_no_double_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && left_speed == '0 && right_speed == '0 |-> !prev_zero_q)
		else $error("repeated all-zero result");

endmodule

bind dual_motor_rumble_envelope_mixer dmrem_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(item.valid),
	.in_ready(item.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.left_speed(result.left_speed),
	.right_speed(result.right_speed)
);

[sim/tb.sv]
module tb;
	import dmrem_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned NUM_PHASES = 9;
	localparam int unsigned ITEMS_PER_PHASE = 215;
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam longint unsigned CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [2:0]  operation;
		logic [17:0] strength_light;
		logic [17:0] strength_heavy;
		logic [15:0] length_light;
		logic [15:0] length_heavy;
		logic [15:0] delay_light;
		logic [15:0] delay_heavy;
		logic [15:0] decay_light;
		logic [15:0] decay_heavy;
		logic [9:0]  elapsed_ms;
		logic [15:0] cur_health;
		logic [15:0] max_health;
	} rumble_item_t;

	typedef struct packed {
		logic [15:0] left_speed;
		logic [15:0] right_speed;
	} drive_pair_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	dmrem_in_if  item_ch();
	dmrem_out_if result_ch();

	dual_motor_rumble_envelope_mixer DUT (
		.clk(clk), .arst_n(arst_n), .item(item_ch.sink), .result(result_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	rumble_item_t pending_items[$];
	drive_pair_t  expected_drives[$];
	int unsigned  fail_count = 0;
	int unsigned  items_sent = 0;
	int unsigned  results_seen = 0;
	longint unsigned cycle_count = 0;
	bit quiet_phase = 0;

	// Predicted configuration.
	int unsigned m_scale, m_rate[2], m_cap[2], m_wait[2], m_hold;

	// Predicted envelope state; index 0 is the light motor, 1 the heavy motor.
	int unsigned m_ptime;
	bit          m_pon;
	int unsigned m_peak[2], m_plen[2], m_pdly[2], m_pdec[2];
	int unsigned m_chg[2], m_cwait[2];
	bit          m_rev[2];
	int          m_hold_left;
	bit          m_charging;
	int unsigned m_van[2], m_van_idle;
	int unsigned m_hit_lvl[2], m_hit_len[2], m_hit_time;
	bit          m_hit_on;
	int          m_last_hp;
	int unsigned m_last_drv[2];

	function automatic int unsigned sat18(longint unsigned v);
		return (v > LVL_MAX) ? LVL_MAX : int'(v);
	endfunction

	function automatic int unsigned scale07(longint unsigned v);
		return sat18(v * 7 / 10);
	endfunction

	function automatic int unsigned umax(int unsigned a, int unsigned b);
		return (a > b) ? a : b;
	endfunction

	function automatic int unsigned add_clip(int unsigned t, int unsigned dt, int unsigned top);
		return (t + dt > top) ? top : t + dt;
	endfunction

	function automatic int unsigned pulse_level(int m);
		longint unsigned fall;
		if (m_ptime < m_pdly[m] || m_ptime >= m_pdly[m] + m_plen[m])
			return 0;
		fall = longint'(m_pdec[m]) * (m_ptime - m_pdly[m]);
		return (fall >= m_peak[m]) ? 0 : m_peak[m] - int'(fall);
	endfunction

	function automatic void charge_one(int m, int unsigned dt);
		longint unsigned lv, stp;
		lv = m_chg[m];
		stp = longint'(m_rate[m]) * dt;
		if (m_cwait[m] > 0) begin
			m_cwait[m] = (m_cwait[m] > dt) ? m_cwait[m] - dt : 0;
			return;
		end
		if (m_rate[m] == 0)
			return;
		if (!m_rev[m])
			lv += stp;
		else
			lv = (lv > stp) ? lv - stp : 0;
		if (m_cap[m] > 0 && lv > m_cap[m])
			lv = m_cap[m];
		m_chg[m] = sat18(lv);
	endfunction

	function automatic void charge_tick(int unsigned dt);
		bit at_cap;
		if (!m_charging) begin
			m_cwait[0] = m_wait[0];
			m_cwait[1] = m_wait[1];
			m_rev[0] = 0;
			m_rev[1] = 0;
			m_hold_left = -1;
		end
		m_charging = 1;
		charge_one(0, dt);
		charge_one(1, dt);
		at_cap = (m_cap[0] == 0 || m_chg[0] >= m_cap[0]) &&
			(m_cap[1] == 0 || m_chg[1] >= m_cap[1]);
		if (at_cap && m_hold > 0) begin
			if (m_hold_left < 0)
				m_hold_left = int'(m_hold);
			m_hold_left -= int'(dt);
			if (m_hold_left <= 0) begin
				m_rev[0] = 1;
				m_rev[1] = 1;
			end
		end
	endfunction

	function automatic void sample_health(int unsigned cur, int unsigned mx);
		longint unsigned drop, ratio, ll, lh;
		if (m_last_hp >= 0 && mx > 0 && m_last_hp > 0 && cur < m_last_hp) begin
			drop = m_last_hp - cur;
			if (drop * 50 > cur) begin
				ratio = drop * 65536 / mx;
				if (ratio > HIT_RMAX)
					ratio = HIT_RMAX;
				m_hit_lvl[0] = sat18(ratio * 2);
				m_hit_lvl[1] = scale07(ratio);
				ll = (ratio * 1000) >> 16;
				lh = (ratio * 5000) / (6 * 65536);
				m_hit_len[0] = (ll < HIT_MIN_L) ? HIT_MIN_L : int'(ll);
				m_hit_len[1] = (lh < HIT_MIN_H) ? HIT_MIN_H : int'(lh);
				m_hit_time = 0;
				m_hit_on = 1;
			end
		end
		m_last_hp = int'(cur);
	endfunction

	function automatic int unsigned drive_level(int unsigned v);
		longint unsigned prod;
		prod = (longint'(v) * m_scale) >> 16;
		if (prod > LVL_FULL)
			prod = LVL_FULL;
		return int'((prod * 65535) >> 16);
	endfunction

	// Mix the four sources; returns 1 when a drive pair is produced.
	function automatic bit mix_drives(output drive_pair_t dp);
		int unsigned pl, ph, cl, ch, vl, vh, dl, dh, wl, wh, lft, rgt;
		int f;
		pl = 0; ph = 0; cl = 0; ch = 0; dl = 0; dh = 0;
		vl = m_van[0];
		vh = m_van[1];
		if (m_pon) begin
			pl = pulse_level(0);
			ph = pulse_level(1);
			if (m_ptime >= m_pdly[0] + m_plen[0] && m_ptime >= m_pdly[1] + m_plen[1])
				m_pon = 0;
		end
		if (m_charging) begin
			cl = m_chg[0];
			ch = scale07(m_chg[1]);
		end
		if ((vl > 0 || vh > 0) && m_van_idle > VAN_IDLE0) begin
			f = 1000 - 3 * (int'(m_van_idle) - 100);
			if (f <= 0) begin
				vl = 0;
				vh = 0;
				m_van[0] = 0;
				m_van[1] = 0;
			end else begin
				vl = int'(longint'(vl) * f / 1000);
				vh = int'(longint'(vh) * f / 1000);
			end
		end
		if (m_hit_on) begin
			if (m_hit_time < m_hit_len[0]) dl = m_hit_lvl[0];
			if (m_hit_time < m_hit_len[1]) dh = m_hit_lvl[1];
			if (m_hit_time >= m_hit_len[0] && m_hit_time >= m_hit_len[1])
				m_hit_on = 0;
		end
		wh = (ph + ch > LVL_FULL) ? LVL_FULL : ph + ch;
		wl = (pl + cl > LVL_FULL) ? LVL_FULL : pl + cl;
		lft = drive_level(umax(umax(vh, wh), dh));
		rgt = drive_level(umax(umax(vl, wl), dl));
		dp = '0;
		if (lft == 0 && rgt == 0 && m_last_drv[0] == 0 && m_last_drv[1] == 0)
			return 0;
		m_last_drv[0] = lft;
		m_last_drv[1] = rgt;
		dp.left_speed = lft[15:0];
		dp.right_speed = rgt[15:0];
		return 1;
	endfunction

	// Advance the predicted state by one accepted item.
	function automatic bit predict_drives(rumble_item_t it, output drive_pair_t dp);
		int unsigned dt;
		dt = it.elapsed_ms;
		dp = '0;
		case (it.operation)
			OP_FRAME, OP_CHARGE: begin
				if (dt == 0 || dt > DT_MAX)
					return 0;
				m_ptime = add_clip(m_ptime, dt, PT_MAX);
				m_van_idle = add_clip(m_van_idle, dt, VAN_IDLE_MX);
				m_hit_time = add_clip(m_hit_time, dt, HIT_T_MAX);
				if (it.operation == OP_CHARGE) begin
					charge_tick(dt);
				end else if (m_charging) begin
					m_charging = 0;
					m_cwait[0] = 0;
					m_cwait[1] = 0;
					m_rev[0] = 0;
					m_rev[1] = 0;
					m_hold_left = -1;
				end
				sample_health(it.cur_health, it.max_health);
				return mix_drives(dp);
			end
			OP_FIRE: begin
				if (it.strength_light == 0 && it.strength_heavy == 0)
					return 0;
				m_peak[0] = sat18(longint'(it.strength_light) + m_chg[0]);
				m_peak[1] = scale07(longint'(it.strength_heavy) + m_chg[1]);
				m_plen[0] = (it.length_light == 0) ? DEF_LEN : it.length_light;
				m_plen[1] = (it.length_heavy == 0) ? DEF_LEN : it.length_heavy;
				m_pdly[0] = it.delay_light;
				m_pdly[1] = it.delay_heavy;
				m_pdec[0] = it.decay_light;
				m_pdec[1] = it.decay_heavy;
				m_ptime = 0;
				m_pon = 1;
				return mix_drives(dp);
			end
			OP_VAN_SET: begin
				m_van[0] = it.strength_light;
				m_van[1] = it.strength_heavy;
				m_van_idle = 0;
				return mix_drives(dp);
			end
			OP_VAN_MAX: begin
				m_van[0] = umax(m_van[0], it.strength_light);
				m_van[1] = umax(m_van[1], it.strength_heavy);
				m_van_idle = 0;
				return mix_drives(dp);
			end
			default: return 0;
		endcase
	endfunction

	function automatic void reset_model();
		m_scale = SCALE_RST;
		m_rate = '{0, 0};
		m_cap = '{0, 0};
		m_wait = '{0, 0};
		m_hold = 0;
		m_ptime = 0;
		m_pon = 0;
		m_peak = '{0, 0};
		m_plen = '{0, 0};
		m_pdly = '{0, 0};
		m_pdec = '{0, 0};
		m_chg = '{0, 0};
		m_cwait = '{0, 0};
		m_rev = '{0, 0};
		m_hold_left = -1;
		m_charging = 0;
		m_van = '{0, 0};
		m_van_idle = 0;
		m_hit_lvl = '{0, 0};
		m_hit_len = '{0, 0};
		m_hit_time = 0;
		m_hit_on = 0;
		m_last_hp = -1;
		m_last_drv = '{0, 0};
	endfunction

	function automatic void model_write(logic [2:0] idx, int unsigned v);
		case (idx)
			REG_SCALE:  m_scale = v & LVL_MAX;
			REG_RATE_L: m_rate[0] = v & 16'hFFFF;
			REG_RATE_H: m_rate[1] = v & 16'hFFFF;
			REG_CAP_L:  m_cap[0] = v & LVL_MAX;
			REG_CAP_H:  m_cap[1] = v & LVL_MAX;
			REG_WAIT_L: m_wait[0] = v & 16'hFFFF;
			REG_WAIT_H: m_wait[1] = v & 16'hFFFF;
			REG_HOLD:   m_hold = v & 16'hFFFF;
			default: ;
		endcase
	endfunction

	// Gap length: mostly none or short, a few long; none at all in quiet phases.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Input driver.
	rumble_item_t cur_item;
	int unsigned  send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		bit busy;
		drive_pair_t dp;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			busy = item_ch.valid;
			if (item_ch.valid && item_ch.ready) begin
				if (predict_drives(cur_item, dp))
					expected_drives.push_back(dp);
				busy = 0;
				send_gap = pick_gap();
			end
			if (!busy) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					busy = 1;
					item_ch.operation      <= cur_item.operation;
					item_ch.strength_light <= cur_item.strength_light;
					item_ch.strength_heavy <= cur_item.strength_heavy;
					item_ch.length_light   <= cur_item.length_light;
					item_ch.length_heavy   <= cur_item.length_heavy;
					item_ch.delay_light    <= cur_item.delay_light;
					item_ch.delay_heavy    <= cur_item.delay_heavy;
					item_ch.decay_light    <= cur_item.decay_light;
					item_ch.decay_heavy    <= cur_item.decay_heavy;
					item_ch.elapsed_ms     <= cur_item.elapsed_ms;
					item_ch.cur_health     <= cur_item.cur_health;
					item_ch.max_health     <= cur_item.max_health;
				end
			end
			item_ch.valid <= busy;
		end
	end

	// Result monitor with random back-pressure.
	int unsigned stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		drive_pair_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (expected_drives.size() == 0) begin
					$error("unexpected result transfer: left_speed=%0d right_speed=%0d",
						result_ch.left_speed, result_ch.right_speed);
					fail_count++;
				end else begin
					want = expected_drives.pop_front();
					if (result_ch.left_speed !== want.left_speed) begin
						$error("left_speed: expected %0d, got %0d",
							want.left_speed, result_ch.left_speed);
						fail_count++;
					end
					if (result_ch.right_speed !== want.right_speed) begin
						$error("right_speed: expected %0d, got %0d",
							want.right_speed, result_ch.right_speed);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				result_ch.ready <= (stall_left == 0);
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, int unsigned v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		model_write(idx, v);
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || item_ch.valid || expected_drives.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic rumble_item_t blank_item(logic [2:0] op, int unsigned dt);
		rumble_item_t it;
		it = '0;
		it.operation = op;
		it.elapsed_ms = dt;
		return it;
	endfunction

	function automatic rumble_item_t frame_item(logic [2:0] op, int unsigned dt,
			int unsigned hp, int unsigned hp_max);
		rumble_item_t it;
		it = blank_item(op, dt);
		it.cur_health = hp;
		it.max_health = hp_max;
		return it;
	endfunction

	function automatic rumble_item_t fire_item(int unsigned sl, int unsigned sh,
			int unsigned ln, int unsigned dly, int unsigned dec);
		rumble_item_t it;
		it = blank_item(OP_FIRE, 0);
		it.strength_light = sl;
		it.strength_heavy = sh;
		it.length_light = ln;
		it.length_heavy = ln;
		it.delay_light = dly;
		it.delay_heavy = dly;
		it.decay_light = dec;
		it.decay_heavy = dec;
		return it;
	endfunction

	// Health tracking for random frames, so that drops of all sizes occur.
	int unsigned hp_now = 100, hp_top = 100;
	int unsigned charge_run = 0;

	function automatic int unsigned rand_level();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(0, LVL_MAX) :
			$urandom_range(0, 90000);
	endfunction

	function automatic int unsigned rand_ms(int unsigned typical);
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) :
			$urandom_range(0, typical);
	endfunction

	// One random item; counted is set when the block does something with it.
	function automatic rumble_item_t rand_item(output bit counted);
		rumble_item_t it;
		int unsigned k;
		it = '0;
		it.strength_light = rand_level();
		it.strength_heavy = rand_level();
		it.length_light = rand_ms(300);
		it.length_heavy = rand_ms(300);
		it.delay_light = rand_ms(60);
		it.delay_heavy = rand_ms(60);
		it.decay_light = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) :
			$urandom_range(0, 2000);
		it.decay_heavy = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) :
			$urandom_range(0, 2000);
		it.elapsed_ms = ($urandom_range(0, 4) == 0) ? $urandom_range(1, DT_MAX) :
			$urandom_range(1, 40);
		k = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0) begin
			hp_top = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) :
				$urandom_range(1, 500);
			hp_now = hp_top;
		end else if ($urandom_range(0, 3) == 0 && hp_now > 0) begin
			hp_now = hp_now - $urandom_range(0, hp_now);
		end else if ($urandom_range(0, 9) == 0) begin
			hp_now = hp_top;
		end
		it.cur_health = hp_now;
		it.max_health = hp_top;
		counted = 1;
		if (charge_run > 0) begin
			charge_run--;
			it.operation = OP_CHARGE;
		end else if (k < 33) begin
			it.operation = OP_FRAME;
		end else if (k < 45) begin
			it.operation = OP_CHARGE;
			charge_run = $urandom_range(2, 15);
		end else if (k < 62) begin
			it.operation = OP_FIRE;
		end else if (k < 73) begin
			it.operation = OP_VAN_SET;
		end else if (k < 84) begin
			it.operation = OP_VAN_MAX;
		end else if (k < 88) begin
			it.operation = OP_FRAME;
			it.elapsed_ms = $urandom_range(0, 1) ? 10'd0 : $urandom_range(DT_MAX + 1, 1023);
			counted = 0;
		end else if (k < 91) begin
			it.operation = OP_CHARGE;
			it.elapsed_ms = $urandom_range(0, 1) ? 10'd0 : $urandom_range(DT_MAX + 1, 1023);
			counted = 0;
		end else if (k < 95) begin
			it.operation = OP_FIRE;
			it.strength_light = 0;
			it.strength_heavy = 0;
			counted = 0;
		end else begin
			it.operation = $urandom_range(OP_UNUSED_LO, OP_UNUSED_HI);
			counted = 0;
		end
		return it;
	endfunction

	// Register values for one phase: extremes first, then random sets.
	task automatic configure_phase(int unsigned p);
		int unsigned v[NUM_REGS];
		case (p)
			0: v = '{LVL_MAX, 2000, 65535, 60000, 0, 3, 0, 20};
			1: v = '{0, 0, 0, 0, 0, 0, 0, 0};
			2: v = '{SCALE_RST, 0, 0, 0, 0, 0, 0, 0};
			3: v = '{LVL_MAX, 65535, 65535, LVL_MAX, LVL_MAX, 65535, 65535, 65535};
			default: begin
				v[REG_SCALE] = $urandom_range(0, 1) ? SCALE_RST : $urandom_range(0, LVL_MAX);
				v[REG_RATE_L] = $urandom_range(0, 4000);
				v[REG_RATE_H] = $urandom_range(0, 4000);
				v[REG_CAP_L] = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 90000);
				v[REG_CAP_H] = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 90000);
				v[REG_WAIT_L] = $urandom_range(0, 30);
				v[REG_WAIT_H] = $urandom_range(0, 30);
				v[REG_HOLD] = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 80);
			end
		endcase
		for (int i = 0; i < NUM_REGS; i++)
			reg_write(i[2:0], v[i]);
	endtask

	// Stimulus.
	initial begin
		int unsigned made;
		bit counted;
		rumble_item_t it;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.operation = OP_FRAME;
		item_ch.strength_light = '0;
		item_ch.strength_heavy = '0;
		item_ch.length_light = '0;
		item_ch.length_heavy = '0;
		item_ch.delay_light = '0;
		item_ch.delay_heavy = '0;
		item_ch.decay_light = '0;
		item_ch.decay_heavy = '0;
		item_ch.elapsed_ms = '0;
		item_ch.cur_health = '0;
		item_ch.max_health = '0;
		result_ch.ready = 1'b0;
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int unsigned p = 0; p < NUM_PHASES; p++) begin
			configure_phase(p);
			quiet_phase = (p % 3 == 2);
			if (p == 0) begin
				// Directed: first health sample, bad steps, unknown codes, empty and
				// extreme fire, a damage pulse, charge up to the cap with hold and
				// reversal, leaving charge, vanilla fade and clear, health extremes.
				pending_items.push_back(frame_item(OP_FRAME, 10, 100, 100));
				pending_items.push_back(frame_item(OP_FRAME, 0, 100, 100));
				pending_items.push_back(frame_item(OP_CHARGE, DT_MAX + 1, 100, 100));
				pending_items.push_back(blank_item(OP_UNUSED_LO, 5));
				pending_items.push_back(blank_item(OP_UNUSED_HI, 5));
				pending_items.push_back(fire_item(0, 0, 10, 0, 0));
				pending_items.push_back(fire_item(LVL_MAX, LVL_MAX, 0, 0, 65535));
				pending_items.push_back(frame_item(OP_FRAME, 1, 90, 100));
				pending_items.push_back(frame_item(OP_CHARGE, 5, 90, 100));
				pending_items.push_back(frame_item(OP_CHARGE, 5, 90, 100));
				pending_items.push_back(frame_item(OP_CHARGE, DT_MAX, 90, 100));
				pending_items.push_back(frame_item(OP_CHARGE, 20, 90, 100));
				pending_items.push_back(frame_item(OP_CHARGE, 20, 90, 100));
				pending_items.push_back(frame_item(OP_FRAME, 7, 90, 100));
				pending_items.push_back(fire_item(1000, 0, 65535, 65535, 0));
				pending_items.push_back(fire_item(0, 1, 1, 0, 1));
				it = blank_item(OP_VAN_SET, 0);
				it.strength_light = LVL_MAX;
				it.strength_heavy = LVL_MAX;
				pending_items.push_back(it);
				pending_items.push_back(blank_item(OP_VAN_MAX, 0));
				pending_items.push_back(frame_item(OP_FRAME, DT_MAX, 90, 100));
				pending_items.push_back(frame_item(OP_FRAME, 200, 0, 65535));
				pending_items.push_back(frame_item(OP_FRAME, 3, 65535, 0));
				pending_items.push_back(frame_item(OP_FRAME, 1023, 65535, 65535));
				pending_items.push_back(frame_item(OP_FRAME, 3, 0, 65535));
				items_sent += 23;
			end
			made = 0;
			while (made < ITEMS_PER_PHASE) begin
				it = rand_item(counted);
				pending_items.push_back(it);
				if (counted) made++;
				items_sent++;
			end
			wait_drained();
		end

		$display("Covered %0d items over %0d register settings; %0d results checked.",
			items_sent, NUM_PHASES, results_seen);
		if (expected_drives.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/dmrem_pkg.sv
hw/rtl/dmrem_ifs.sv
hw/rtl/dmrem_mul.sv
hw/rtl/dmrem_div.sv
hw/rtl/dmrem_regs.sv
hw/rtl/dual_motor_rumble_envelope_mixer.sv
hw/rtl/dmrem_chk.sv
sim/tb.sv
